// ===== rtl/core/pva_pkg.sv =====
// Shared constants, codes and types of the priority voice allocator.
package pva_pkg;

   localparam int VOICE_COUNT_DEF   = 64;
   localparam int PRIORITY_BITS_DEF = 8;

   localparam int OPCODE_W    = 2;
   localparam int PRIO_REQ_W  = 8;
   localparam int VOICE_IDX_W = 6;
   localparam int STATUS_W    = 3;
   localparam int IN_USE_W    = 7;
   localparam int STAMP_W     = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ACQUIRE  = 2'd0,
      OP_FREE     = 2'd1,
      OP_SET_PRIO = 2'd2,
      OP_RESERVED = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_GRANT_FREE        = 3'd0,
      STAT_GRANT_STOLEN      = 3'd1,
      STAT_REFUSE_DISABLED   = 3'd2,
      STAT_REFUSE_NONE_LOWER = 3'd3,
      STAT_DONE              = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_FREE_SCAN,
      S_STEAL_SCAN,
      S_GRANT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic prio_we;
      logic stamp_we;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== rtl/core/pva_if.sv =====
// Request and response channel interfaces of the priority voice allocator.
interface pva_req_if;
   logic                            valid;
   logic                            ready;
   logic [pva_pkg::OPCODE_W-1:0]    opcode;
   logic [pva_pkg::PRIO_REQ_W-1:0]  priority_req;
   logic [pva_pkg::VOICE_IDX_W-1:0] voice_index;

   modport source (output valid, opcode, priority_req, voice_index, input ready);
   modport sink   (input valid, opcode, priority_req, voice_index, output ready);
endinterface

interface pva_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pva_pkg::STATUS_W-1:0]    status;
   logic [pva_pkg::VOICE_IDX_W-1:0] granted_voice;
   logic [pva_pkg::IN_USE_W-1:0]    voices_in_use;

   modport source (output valid, status, granted_voice, voices_in_use, input ready);
   modport sink   (input valid, status, granted_voice, voices_in_use, output ready);
endinterface

// ===== rtl/core/pva_voice_mem.sv =====
// Per-voice priority and acquisition stamp memories with a registered read port.
module pva_voice_mem #(
   parameter int  VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF,
   parameter int  PRIO_W      = pva_pkg::PRIORITY_BITS_DEF,
   localparam int VIDX_W      = $clog2(VOICE_COUNT),
   localparam int STAMP_W     = pva_pkg::STAMP_W
) (
   input  logic                 clock,
   input  pva_pkg::mem_ctl_type mem_ctl,
   input  logic [VIDX_W-1:0]    wr_addr,
   input  logic [PRIO_W-1:0]    wr_prio,
   input  logic [STAMP_W-1:0]   wr_stamp,
   input  logic [VIDX_W-1:0]    rd_addr,
   output logic [PRIO_W-1:0]    rd_prio,
   output logic [STAMP_W-1:0]   rd_stamp
);

   logic [PRIO_W-1:0]  prio_mem  [VOICE_COUNT];
   logic [STAMP_W-1:0] stamp_mem [VOICE_COUNT];
   logic [PRIO_W-1:0]  rd_prio_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.prio_we) begin
         prio_mem[wr_addr] <= wr_prio;
      end
      if (mem_ctl.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      if (mem_ctl.rd_en) begin
         rd_prio_ff  <= prio_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_prio  = rd_prio_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

// ===== rtl/core/pva_ctrl.sv =====
// Sequencer, scan compare unit and voice occupancy state of the allocator.
module pva_ctrl #(
   parameter int  VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF,
   parameter int  PRIO_W      = pva_pkg::PRIORITY_BITS_DEF,
   localparam int VIDX_W      = $clog2(VOICE_COUNT),
   localparam int STAMP_W     = pva_pkg::STAMP_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic                 csr_write_data,
   pva_req_if.sink              req_bus,
   pva_rsp_if.source            rsp_bus,
   output pva_pkg::mem_ctl_type mem_ctl,
   output logic [VIDX_W-1:0]    wr_addr,
   output logic [PRIO_W-1:0]    wr_prio,
   output logic [STAMP_W-1:0]   wr_stamp,
   output logic [VIDX_W-1:0]    rd_addr,
   input  logic [PRIO_W-1:0]    rd_prio,
   input  logic [STAMP_W-1:0]   rd_stamp
);

   localparam int VCW   = $clog2(VOICE_COUNT + 1);
   localparam int IDX_W = pva_pkg::VOICE_IDX_W;
   localparam int CNT_W = pva_pkg::IN_USE_W;
   localparam int ST_W  = pva_pkg::STATUS_W;

   pva_pkg::state_type  state_ff, state_in;
   pva_pkg::opcode_type op_ff;
   pva_pkg::status_type status_ff;

   logic [PRIO_W-1:0]      prio_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [VCW-1:0]         scan_ff;
   logic [VIDX_W-1:0]      best_idx_ff;
   logic [PRIO_W-1:0]      best_prio_ff;
   logic [STAMP_W-1:0]     best_stamp_ff;
   logic                   found_ff;
   logic [VOICE_COUNT-1:0] in_use_ff;
   logic [VCW-1:0]         count_ff;
   logic [STAMP_W-1:0]     acq_ff;
   logic                   enabled_ff;
   logic                   rsp_valid_ff;
   logic [ST_W-1:0]        rsp_status_ff;
   logic [IDX_W-1:0]       rsp_voice_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic              req_fire;
   logic              rsp_free;
   logic              load_rsp;
   logic              idx_in_range;
   logic [VIDX_W-1:0] idx_v;
   logic [VIDX_W-1:0] scan_v;
   logic [VIDX_W-1:0] eval_idx;
   logic [VIDX_W-1:0] use_addr;
   logic              use_bit;
   logic              scan_last;
   logic              cand_ok;
   logic [STAMP_W-1:0] stamp_next;
   logic              granted;

   assign req_fire     = req_bus.valid && req_bus.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   assign idx_in_range = 32'(idx_ff) < 32'(VOICE_COUNT);
   assign idx_v        = VIDX_W'(idx_ff);
   assign scan_v       = VIDX_W'(scan_ff);
   assign eval_idx     = VIDX_W'(scan_ff - VCW'(1));
   assign use_addr     = (state_ff == pva_pkg::S_FREE_SCAN) ? scan_v : idx_v;
   assign use_bit      = in_use_ff[use_addr];
   assign scan_last    = scan_ff == VCW'(VOICE_COUNT);
   assign stamp_next   = acq_ff + STAMP_W'(1);
   assign granted      = (status_ff == pva_pkg::STAT_GRANT_FREE) ||
                         (status_ff == pva_pkg::STAT_GRANT_STOLEN);

   // A candidate must sit strictly below the request; ties go to the older stamp,
   // and equal stamps keep the lower voice already held.
   assign cand_ok = (rd_prio < prio_ff) &&
                    (!found_ff || (rd_prio < best_prio_ff) ||
                     ((rd_prio == best_prio_ff) && (rd_stamp < best_stamp_ff)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pva_pkg::S_IDLE: begin
            if (req_fire) begin
               if (pva_pkg::opcode_type'(req_bus.opcode) == pva_pkg::OP_ACQUIRE) begin
                  if (!enabled_ff) begin
                     state_in = pva_pkg::S_FINISH;
                  end else if (count_ff != VCW'(VOICE_COUNT)) begin
                     state_in = pva_pkg::S_FREE_SCAN;
                  end else begin
                     state_in = pva_pkg::S_STEAL_SCAN;
                  end
               end else begin
                  state_in = pva_pkg::S_UPDATE;
               end
            end
         end
         pva_pkg::S_UPDATE: begin
            state_in = pva_pkg::S_FINISH;
         end
         pva_pkg::S_FREE_SCAN: begin
            if (!use_bit) begin
               state_in = pva_pkg::S_GRANT;
            end
         end
         pva_pkg::S_STEAL_SCAN: begin
            if (scan_last) begin
               state_in = (found_ff || cand_ok) ? pva_pkg::S_GRANT : pva_pkg::S_FINISH;
            end
         end
         pva_pkg::S_GRANT: begin
            state_in = pva_pkg::S_FINISH;
         end
         pva_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = pva_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pva_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_bus.ready    = 1'b0;
      mem_ctl          = '0;
      load_rsp         = 1'b0;
      wr_addr          = idx_v;
      wr_prio          = prio_ff;
      wr_stamp         = stamp_next;
      rd_addr          = scan_v;
      case (state_ff)
         pva_pkg::S_IDLE: begin
            req_bus.ready = 1'b1;
         end
         pva_pkg::S_UPDATE: begin
            mem_ctl.prio_we = (op_ff == pva_pkg::OP_SET_PRIO) && idx_in_range;
         end
         pva_pkg::S_STEAL_SCAN: begin
            mem_ctl.rd_en = !scan_last;
         end
         pva_pkg::S_GRANT: begin
            mem_ctl.prio_we  = 1'b1;
            mem_ctl.stamp_we = 1'b1;
            wr_addr          = best_idx_ff;
         end
         pva_pkg::S_FINISH: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pva_pkg::S_IDLE;
         enabled_ff   <= 1'b0;
         in_use_ff    <= '0;
         count_ff     <= '0;
         acq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            enabled_ff <= csr_write_data;
         end
         if (state_ff == pva_pkg::S_UPDATE && op_ff == pva_pkg::OP_FREE &&
             idx_in_range && use_bit) begin
            in_use_ff[idx_v] <= 1'b0;
            count_ff         <= count_ff - VCW'(1);
         end
         if (state_ff == pva_pkg::S_GRANT) begin
            in_use_ff[best_idx_ff] <= 1'b1;
            acq_ff                 <= stamp_next;
            if (status_ff == pva_pkg::STAT_GRANT_FREE) begin
               count_ff <= count_ff + VCW'(1);
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pva_pkg::S_IDLE: begin
            if (req_fire) begin
               op_ff    <= pva_pkg::opcode_type'(req_bus.opcode);
               prio_ff  <= PRIO_W'(req_bus.priority_req);
               idx_ff   <= req_bus.voice_index;
               scan_ff  <= '0;
               found_ff <= 1'b0;
               if (pva_pkg::opcode_type'(req_bus.opcode) != pva_pkg::OP_ACQUIRE) begin
                  status_ff <= pva_pkg::STAT_DONE;
               end else if (!enabled_ff) begin
                  status_ff <= pva_pkg::STAT_REFUSE_DISABLED;
               end else begin
                  status_ff <= pva_pkg::STAT_GRANT_FREE;
               end
            end
         end
         pva_pkg::S_FREE_SCAN: begin
            if (!use_bit) begin
               best_idx_ff <= scan_v;
            end else begin
               scan_ff <= scan_ff + VCW'(1);
            end
         end
         pva_pkg::S_STEAL_SCAN: begin
            if (!scan_last) begin
               scan_ff <= scan_ff + VCW'(1);
            end
            if (scan_ff != '0 && cand_ok) begin
               best_idx_ff   <= eval_idx;
               best_prio_ff  <= rd_prio;
               best_stamp_ff <= rd_stamp;
               found_ff      <= 1'b1;
            end
            if (scan_last) begin
               status_ff <= (found_ff || cand_ok) ? pva_pkg::STAT_GRANT_STOLEN
                                                  : pva_pkg::STAT_REFUSE_NONE_LOWER;
            end
         end
         default: begin
         end
      endcase
      if (load_rsp) begin
         rsp_status_ff <= ST_W'(status_ff);
         rsp_voice_ff  <= granted ? IDX_W'(best_idx_ff) : '0;
         rsp_count_ff  <= CNT_W'(count_ff);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.granted_voice = rsp_voice_ff;
   assign rsp_bus.voices_in_use = rsp_count_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == VCW'($countones(in_use_ff)))
      else $error("voice count differs from the occupancy vector");

   a_free_scan_has_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == pva_pkg::S_FREE_SCAN |-> count_ff != VCW'(VOICE_COUNT))
      else $error("free scan entered with every voice in use");

   a_steal_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pva_pkg::S_GRANT && status_ff == pva_pkg::STAT_GRANT_STOLEN)
      |-> (&in_use_ff))
      else $error("voice stolen while a free voice exists");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == pva_pkg::S_STEAL_SCAN |-> scan_ff <= VCW'(VOICE_COUNT))
      else $error("steal scan ran past the last voice");

endmodule

// ===== rtl/core/priority_voice_allocator_top.sv =====
// Top level of the priority voice allocator.
// An acquire searches the occupancy vector from index 0 for a free voice. When every voice
// is in use it must steal instead: the sequencer then walks the whole voice table one entry
// per cycle through a single compare unit and the one read port of the priority and stamp
// memories, and an acquire that finds no voice with a lower priority is refused. Free,
// set-priority and reserved requests pass through the update state, and an acquire refused
// because voices are disabled goes straight to the finish state.
// A new request beat is taken only while the sequencer is idle, which includes the time a
// finished response beat still waits in the output register. The user must write the enable
// register through csr_write_en and csr_write_data only while the block is idle; the block
// itself does not enforce this. No memory clearing pass follows reset.
module priority_voice_allocator_top #(
   parameter int VOICE_COUNT   = pva_pkg::VOICE_COUNT_DEF,
   parameter int PRIORITY_BITS = pva_pkg::PRIORITY_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       csr_write_en,
   input logic       csr_write_data,
   pva_req_if.sink   req_bus,
   pva_rsp_if.source rsp_bus
);

   localparam int PRIO_W  = (PRIORITY_BITS < pva_pkg::PRIO_REQ_W) ? PRIORITY_BITS
                                                                  : pva_pkg::PRIO_REQ_W;
   localparam int VIDX_W  = $clog2(VOICE_COUNT);
   localparam int STAMP_W = pva_pkg::STAMP_W;

   pva_pkg::mem_ctl_type mem_ctl;
   logic [VIDX_W-1:0]    wr_addr;
   logic [VIDX_W-1:0]    rd_addr;
   logic [PRIO_W-1:0]    wr_prio;
   logic [PRIO_W-1:0]    rd_prio;
   logic [STAMP_W-1:0]   wr_stamp;
   logic [STAMP_W-1:0]   rd_stamp;

   pva_ctrl #(
      .VOICE_COUNT (VOICE_COUNT),
      .PRIO_W      (PRIO_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mem_ctl        (mem_ctl),
      .wr_addr        (wr_addr),
      .wr_prio        (wr_prio),
      .wr_stamp       (wr_stamp),
      .rd_addr        (rd_addr),
      .rd_prio        (rd_prio),
      .rd_stamp       (rd_stamp)
   );

   pva_voice_mem #(
      .VOICE_COUNT (VOICE_COUNT),
      .PRIO_W      (PRIO_W)
   ) u_voice_mem (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_prio  (wr_prio),
      .wr_stamp (wr_stamp),
      .rd_addr  (rd_addr),
      .rd_prio  (rd_prio),
      .rd_stamp (rd_stamp)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the priority voice allocator with a voice pool predictor.
module tb_top;

   localparam int          VOICES       = pva_pkg::VOICE_COUNT_DEF;
   localparam int          VIDX_W       = pva_pkg::VOICE_IDX_W;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned QUIET_TAIL   = 100;
   localparam int unsigned HOLD_AT      = 150;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned SETTLE       = 2 * VOICES;

   typedef struct packed {
      pva_pkg::status_type            status;
      logic [VIDX_W-1:0]              voice;
      logic [pva_pkg::IN_USE_W-1:0]   count;
   } voice_result_type;

   class voice_pool_board_type;
      bit                           enabled;
      bit                           busy[VOICES];
      logic [7:0]                   held_prio[VOICES];
      logic [pva_pkg::STAMP_W-1:0]  stamp[VOICES];
      logic [pva_pkg::STAMP_W-1:0]  grant_count;
      voice_result_type             awaited_results[$];
      int unsigned                  mismatches;

      function new();
         enabled = 1'b0;
         grant_count = '0;
         mismatches = 0;
         foreach (busy[i]) begin
            busy[i] = 1'b0;
            held_prio[i] = '0;
            stamp[i] = '0;
         end
      endfunction

      function int unsigned in_use_count();
         int unsigned n;
         n = 0;
         foreach (busy[i]) n += busy[i];
         return n;
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      function pva_pkg::status_type acquire(logic [7:0] p, output logic [VIDX_W-1:0] voice);
         int                  pick;
         pva_pkg::status_type st;
         pick = -1;
         st = pva_pkg::STAT_GRANT_FREE;
         voice = '0;
         if (!enabled) return pva_pkg::STAT_REFUSE_DISABLED;
         for (int i = 0; i < VOICES; i++) begin
            if (!busy[i]) begin
               pick = i;
               break;
            end
         end
         if (pick < 0) begin
            for (int i = 0; i < VOICES; i++) begin
               if (held_prio[i] < p) begin
                  if (pick < 0 || held_prio[i] < held_prio[pick] ||
                      (held_prio[i] == held_prio[pick] && stamp[i] < stamp[pick]))
                     pick = i;
               end
            end
            if (pick < 0) return pva_pkg::STAT_REFUSE_NONE_LOWER;
            st = pva_pkg::STAT_GRANT_STOLEN;
         end
         busy[pick] = 1'b1;
         grant_count = grant_count + 1'b1;
         stamp[pick] = grant_count;
         held_prio[pick] = p;
         voice = VIDX_W'(pick);
         return st;
      endfunction

      function void note_request(pva_pkg::opcode_type op, logic [7:0] p,
                                 logic [VIDX_W-1:0] idx);
         voice_result_type r;
         r.status = pva_pkg::STAT_DONE;
         r.voice = '0;
         case (op)
            pva_pkg::OP_ACQUIRE:  r.status = acquire(p, r.voice);
            pva_pkg::OP_FREE:     busy[idx] = 1'b0;
            pva_pkg::OP_SET_PRIO: held_prio[idx] = p;
            default: ;
         endcase
         r.count = pva_pkg::IN_USE_W'(in_use_count());
         awaited_results.push_back(r);
      endfunction

      function void check_response(logic [pva_pkg::STATUS_W-1:0] st,
                                   logic [VIDX_W-1:0] voice,
                                   logic [pva_pkg::IN_USE_W-1:0] count);
         voice_result_type e;
         if (awaited_results.size() == 0) begin
            $error("Response beat arrived with no request outstanding.");
            mismatches++;
            return;
         end
         e = awaited_results.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            mismatches++;
         end
         if (voice !== e.voice) begin
            $error("granted_voice: expected %0d, actual %0d", e.voice, voice);
            mismatches++;
         end
         if (count !== e.count) begin
            $error("voices_in_use: expected %0d, actual %0d", e.count, count);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic csr_write_data;

   pva_req_if req_bus();
   pva_rsp_if rsp_bus();

   priority_voice_allocator_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus)
   );

   voice_pool_board_type board = new();
   int unsigned          random_sent = 0;
   int unsigned          cycle_count = 0;
   int unsigned          stuck_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit idling_allowed();
      return random_sent < RANDOM_ITEMS - QUIET_TAIL && (cycle_count / 300) % 4 != 3;
   endfunction

   function automatic logic [7:0] pick_priority();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h02;
         3: return 8'hFE;
         4: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_request(pva_pkg::opcode_type op, logic [7:0] p,
                               logic [VIDX_W-1:0] idx);
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.priority_req <= p;
      req_bus.voice_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(op, p, idx);
   endtask

   task automatic maybe_pause();
      if (idling_allowed() && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic set_voices_enabled(bit value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      board.enabled = value;
      csr_write_en <= 1'b0;
   endtask

   task automatic run_traffic(int unsigned count);
      int unsigned        r;
      logic [7:0]         p;
      logic [VIDX_W-1:0]  idx;
      repeat (count) begin
         maybe_pause();
         r = $urandom_range(0, 99);
         p = pick_priority();
         idx = VIDX_W'($urandom_range(0, VOICES - 1));
         if (board.in_use_count() < VOICES && r < 85)
            send_request(pva_pkg::OP_ACQUIRE, p, idx);
         else if (r < 50)
            send_request(pva_pkg::OP_ACQUIRE, p, idx);
         else if (r < 65)
            send_request(pva_pkg::OP_SET_PRIO, p, idx);
         else if (r < 82)
            send_request(pva_pkg::OP_FREE, p, idx);
         else if (r < 92)
            send_request(pva_pkg::OP_ACQUIRE, r[0] ? 8'hFF : 8'h00, idx);
         else
            send_request(pva_pkg::OP_RESERVED, p, idx);
         random_sent++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset)
         stuck_cycles <= 0;
      else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response(rsp_bus.status, rsp_bus.granted_voice, rsp_bus.voices_in_use);
   end

   initial begin : response_drain
      int unsigned hold;
      bit          long_hold_done;
      hold = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!long_hold_done && random_sent >= HOLD_AT) begin
            long_hold_done = 1'b1;
            hold = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else if (idling_allowed() && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (stuck_cycles < STALL_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      req_bus.valid <= 1'b0;
      req_bus.opcode <= pva_pkg::OP_ACQUIRE;
      req_bus.priority_req <= '0;
      req_bus.voice_index <= '0;
      csr_write_en <= 1'b0;
      csr_write_data <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Voices are disabled out of reset, so acquires are refused.
      send_request(pva_pkg::OP_ACQUIRE, 8'h80, 6'd0);
      send_request(pva_pkg::OP_SET_PRIO, 8'hFF, 6'd63);
      send_request(pva_pkg::OP_FREE, 8'h00, 6'd0);
      send_request(pva_pkg::OP_RESERVED, 8'hFF, 6'd63);
      set_voices_enabled(1'b1);

      send_request(pva_pkg::OP_ACQUIRE, 8'h00, 6'd0);
      send_request(pva_pkg::OP_ACQUIRE, 8'hFF, 6'd0);
      send_request(pva_pkg::OP_ACQUIRE, 8'hAA, 6'd63);
      send_request(pva_pkg::OP_SET_PRIO, 8'h00, 6'd1);
      send_request(pva_pkg::OP_FREE, 8'h00, 6'd0);
      send_request(pva_pkg::OP_ACQUIRE, 8'h55, 6'd0);
      send_request(pva_pkg::OP_FREE, 8'h00, 6'd63);
      send_request(pva_pkg::OP_SET_PRIO, 8'h2A, 6'd42);
      send_request(pva_pkg::OP_RESERVED, 8'h00, 6'd0);
      send_request(pva_pkg::OP_FREE, 8'h00, 6'd1);
      send_request(pva_pkg::OP_FREE, 8'h00, 6'd1);

      // The pool fills up early, so most later acquires must steal or be refused.
      run_traffic(250);
      wait_drained();
      set_voices_enabled(1'b0);
      run_traffic(30);
      set_voices_enabled(1'b1);
      run_traffic(RANDOM_ITEMS - 280);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
